/* rtl/ctcu_pkg.sv */
package ctcu_pkg;

   // Field widths
   localparam int KindWidth     = 1;
   localparam int KeyWidth      = 3;
   localparam int PhaseWidth    = 3;
   localparam int MinutesWidth  = 7;
   localparam int SecondsWidth  = 6;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 7;

   // Timer phases
   typedef enum logic [PhaseWidth-1:0] {
      PHASE_IDLE    = 3'd0,
      PHASE_SETTING = 3'd1,
      PHASE_RUNNING = 3'd2,
      PHASE_PAUSED  = 3'd3,
      PHASE_DONE    = 3'd4
   } phase_type;

   // Key codes
   localparam logic [KeyWidth-1:0] BTN_MICRO       = 3'd0;
   localparam logic [KeyWidth-1:0] BTN_GRILL       = 3'd1;
   localparam logic [KeyWidth-1:0] BTN_START       = 3'd2;
   localparam logic [KeyWidth-1:0] BTN_STOP        = 3'd3;
   localparam logic [KeyWidth-1:0] BTN_TEN_SECONDS = 3'd4;
   localparam logic [KeyWidth-1:0] BTN_ONE_MINUTE  = 3'd5;
   localparam logic [KeyWidth-1:0] BTN_TEN_MINUTES = 3'd6;

   // Item kinds
   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Control register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_MINUTES = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_QUICK_START = 2'd1;

   // Reset values and time constants
   localparam logic [MinutesWidth-1:0] MaxMinutesReset = 7'd90;
   localparam logic [SecondsWidth-1:0] QuickStartReset = 6'd30;
   localparam logic [MinutesWidth-1:0] MinutesLimit    = 7'd99;
   localparam logic [SecondsWidth-1:0] SecondsTop      = 6'd59;
   localparam logic [MinutesWidth-1:0] TenStep         = 7'd10;
   localparam logic [MinutesWidth-1:0] SecondsPerMin   = 7'd60;
   localparam logic [SecondsWidth-1:0] RunBonus        = 6'd30;

   typedef struct packed {
      phase_type                phase;
      logic                     grill;
      logic [MinutesWidth-1:0]  minutes;
      logic [SecondsWidth-1:0]  seconds;
   } timer_state_type;

   typedef struct packed {
      logic [MinutesWidth-1:0]  max_minutes;
      logic [SecondsWidth-1:0]  quick_seconds;
   } timer_cfg_type;

   typedef struct packed {
      logic beep;
      logic alert;
   } step_flags_type;

endpackage

/* rtl/ctcu_ifs.sv */
interface ctcu_req_if;
   logic                          valid;
   logic                          ready;
   logic [ctcu_pkg::KindWidth-1:0] kind;
   logic [ctcu_pkg::KeyWidth-1:0]  key_code;

   modport source (output valid, output kind, output key_code, input ready);
   modport sink   (input valid, input kind, input key_code, output ready);
endinterface

interface ctcu_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ctcu_pkg::PhaseWidth-1:0]   phase;
   logic                              heat_is_grill;
   logic                              micro_relay;
   logic                              grill_relay;
   logic [ctcu_pkg::MinutesWidth-1:0] minutes_left;
   logic [ctcu_pkg::SecondsWidth-1:0] seconds_left;
   logic                              beep;
   logic                              alert;

   modport source (output valid, output phase, output heat_is_grill, output micro_relay,
                   output grill_relay, output minutes_left, output seconds_left,
                   output beep, output alert, input ready);
   modport sink   (input valid, input phase, input heat_is_grill, input micro_relay,
                   input grill_relay, input minutes_left, input seconds_left,
                   input beep, input alert, output ready);
endinterface

interface ctcu_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ctcu_pkg::CsrIndexWidth-1:0] index;
   logic [ctcu_pkg::CsrDataWidth-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/ctcu_next.sv */
module ctcu_next (
   input  ctcu_pkg::timer_state_type           cur,
   input  ctcu_pkg::timer_cfg_type             cfg,
   input  logic [ctcu_pkg::KindWidth-1:0]      kind,
   input  logic [ctcu_pkg::KeyWidth-1:0]       key_code,
   output ctcu_pkg::timer_state_type           nxt,
   output ctcu_pkg::step_flags_type            flags
);
   import ctcu_pkg::*;

   logic [MinutesWidth-1:0] max_eff;
   logic [SecondsWidth-1:0] quick_eff;
   logic                    is_key;
   logic                    below_max;
   logic                    time_zero;
   logic [MinutesWidth-1:0] sec_plus_ten;
   logic [MinutesWidth-1:0] min_plus_ten;
   logic                    sec_carry;
   phase_type               phase_mid;
   logic                    finish;
   logic                    beep;
   logic                    grill_in;
   logic [MinutesWidth-1:0] minutes_in;
   logic [SecondsWidth-1:0] seconds_in;

   // Clamp the control registers into their legal ranges
   always_comb begin
      if (cfg.max_minutes == '0) begin
         max_eff = MinutesWidth'(1);
      end else if (cfg.max_minutes > MinutesLimit) begin
         max_eff = MinutesLimit;
      end else begin
         max_eff = cfg.max_minutes;
      end
      if (cfg.quick_seconds == '0) begin
         quick_eff = SecondsWidth'(1);
      end else if (cfg.quick_seconds > SecondsTop) begin
         quick_eff = SecondsTop;
      end else begin
         quick_eff = cfg.quick_seconds;
      end
   end

   // Shared conditions
   assign is_key       = (kind == KIND_KEY) && (key_code <= BTN_TEN_MINUTES);
   assign below_max    = cur.minutes < max_eff;
   assign time_zero    = (cur.minutes == '0) && (cur.seconds == '0);
   assign sec_plus_ten = {1'b0, cur.seconds} + TenStep;
   assign sec_carry    = sec_plus_ten >= SecondsPerMin;
   assign min_plus_ten = cur.minutes + TenStep;

   // Next phase
   always_comb begin
      phase_mid = cur.phase;
      if (is_key) begin
         case (cur.phase)
            PHASE_IDLE: begin
               if (key_code inside {BTN_MICRO, BTN_GRILL}) begin
                  phase_mid = PHASE_SETTING;
               end else if (key_code == BTN_START) begin
                  phase_mid = PHASE_RUNNING;
               end
            end
            PHASE_SETTING: begin
               if (key_code == BTN_START && !time_zero) begin
                  phase_mid = PHASE_RUNNING;
               end
            end
            PHASE_RUNNING: begin
               if (key_code == BTN_STOP) begin
                  phase_mid = PHASE_PAUSED;
               end
            end
            PHASE_PAUSED: begin
               if (key_code == BTN_START) begin
                  phase_mid = PHASE_RUNNING;
               end
            end
            PHASE_DONE: begin
               phase_mid = PHASE_IDLE;
            end
            default: begin
               phase_mid = cur.phase;
            end
         endcase
      end
   end

   // Time, heating type and acknowledge beep
   always_comb begin
      minutes_in = cur.minutes;
      seconds_in = cur.seconds;
      grill_in   = cur.grill;
      beep       = 1'b0;
      if (kind == KIND_TICK) begin
         if (cur.phase == PHASE_RUNNING) begin
            if (cur.seconds != '0) begin
               seconds_in = cur.seconds - SecondsWidth'(1);
            end else if (cur.minutes != '0) begin
               minutes_in = cur.minutes - MinutesWidth'(1);
               seconds_in = SecondsTop;
            end
         end
      end else if (is_key) begin
         case (cur.phase)
            PHASE_IDLE: begin
               if (key_code inside {BTN_MICRO, BTN_GRILL}) begin
                  beep       = 1'b1;
                  grill_in   = (key_code == BTN_GRILL);
                  minutes_in = '0;
                  seconds_in = '0;
               end else if (key_code == BTN_START) begin
                  beep       = 1'b1;
                  grill_in   = 1'b0;
                  minutes_in = '0;
                  seconds_in = quick_eff;
               end
            end
            PHASE_SETTING: begin
               case (key_code)
                  BTN_TEN_SECONDS: begin
                     if (below_max) begin
                        beep = 1'b1;
                        if (sec_carry) begin
                           seconds_in = SecondsWidth'(sec_plus_ten - SecondsPerMin);
                           minutes_in = cur.minutes + MinutesWidth'(1);
                        end else begin
                           seconds_in = SecondsWidth'(sec_plus_ten);
                        end
                     end
                  end
                  BTN_ONE_MINUTE: begin
                     if (below_max) begin
                        beep       = 1'b1;
                        minutes_in = cur.minutes + MinutesWidth'(1);
                     end
                  end
                  BTN_TEN_MINUTES: begin
                     // Reaching the cap pins the time to max:00 silently
                     if (below_max) begin
                        if (min_plus_ten >= max_eff) begin
                           minutes_in = max_eff;
                           seconds_in = '0;
                        end else begin
                           beep       = 1'b1;
                           minutes_in = min_plus_ten;
                        end
                     end
                  end
                  BTN_STOP: begin
                     beep       = 1'b1;
                     minutes_in = '0;
                     seconds_in = '0;
                  end
                  BTN_MICRO, BTN_GRILL: begin
                     beep     = 1'b1;
                     grill_in = (key_code == BTN_GRILL);
                  end
                  BTN_START: begin
                     beep = !time_zero;
                  end
                  default: begin
                     beep = 1'b0;
                  end
               endcase
            end
            PHASE_RUNNING: begin
               if (key_code == BTN_STOP) begin
                  beep = 1'b1;
               end else if (key_code == BTN_START) begin
                  if (below_max && cur.seconds < RunBonus) begin
                     beep       = 1'b1;
                     seconds_in = cur.seconds + RunBonus;
                  end
               end
            end
            PHASE_PAUSED: begin
               beep = (key_code == BTN_START);
            end
            PHASE_DONE: begin
               beep = 1'b1;
            end
            default: begin
               beep = 1'b0;
            end
         endcase
      end
   end

   // Running out of time ends in done
   assign finish = (phase_mid == PHASE_RUNNING) && (minutes_in == '0) && (seconds_in == '0);

   assign nxt.phase   = finish ? PHASE_DONE : phase_mid;
   assign nxt.grill   = grill_in;
   assign nxt.minutes = minutes_in;
   assign nxt.seconds = seconds_in;
   assign flags.beep  = beep;
   assign flags.alert = finish;

endmodule

/* rtl/cooking_timer_controller_unit.sv */
// Cooking timer controller: takes one transaction per cycle on req_ch (a key press or a
// one-second tick) and returns exactly one result per transaction on rsp_ch, in order.
// A transaction is registered at the input, the phase/time update is combinational
// next-state logic between the input and output registers, and the result is registered
// at the output. Throughput is one transaction per cycle while rsp_ch.ready is high; the
// output register and the input register together let one new transaction in while a
// result waits. The csr_ch write port is always ready; index 0 sets max_minutes (0 reads
// as 1, above 99 as 99), index 1 sets quick_start_seconds from data[5:0] (0 reads as 1,
// above 59 as 59). Other indexes are ignored. Write these only while no transaction is
// in flight.
module cooking_timer_controller_unit (
   input logic        clock,
   input logic        reset,
   ctcu_req_if.sink   req_ch,
   ctcu_rsp_if.source rsp_ch,
   ctcu_csr_if.sink   csr_ch
);
   import ctcu_pkg::*;

   // Input stage
   logic                    in_valid_ff, in_valid_in;
   logic [KindWidth-1:0]    in_kind_ff;
   logic [KeyWidth-1:0]     in_key_ff;
   // Timer state and configuration
   timer_state_type         state_ff, state_in;
   timer_cfg_type           cfg_ff, cfg_in;
   // Result stage
   logic                    rsp_valid_ff, rsp_valid_in;
   timer_state_type         rsp_state_ff;
   step_flags_type          rsp_flags_ff;

   logic                    req_take;
   logic                    advance;
   step_flags_type          step_flags;

   // Handshake control
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);
   end

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_MAX_MINUTES: cfg_in.max_minutes   = MinutesWidth'(csr_ch.data);
            CSR_QUICK_START: cfg_in.quick_seconds = SecondsWidth'(csr_ch.data);
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // Per-transaction update
   ctcu_next u_next (
      .cur      (state_ff),
      .cfg      (cfg_ff),
      .kind     (in_kind_ff),
      .key_code (in_key_ff),
      .nxt      (state_in),
      .flags    (step_flags)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         cfg_ff.max_minutes   <= MaxMinutesReset;
         cfg_ff.quick_seconds <= QuickStartReset;
         state_ff.phase    <= PHASE_IDLE;
         state_ff.grill    <= 1'b0;
         state_ff.minutes  <= '0;
         state_ff.seconds  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_ch.kind;
         in_key_ff  <= req_ch.key_code;
      end
      if (advance) begin
         rsp_state_ff <= state_in;
         rsp_flags_ff <= step_flags;
      end
   end

   // Result drive
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.phase         = rsp_state_ff.phase;
   assign rsp_ch.heat_is_grill = rsp_state_ff.grill;
   assign rsp_ch.micro_relay   = (rsp_state_ff.phase == PHASE_RUNNING) && !rsp_state_ff.grill;
   assign rsp_ch.grill_relay   = (rsp_state_ff.phase == PHASE_RUNNING) && rsp_state_ff.grill;
   assign rsp_ch.minutes_left  = rsp_state_ff.minutes;
   assign rsp_ch.seconds_left  = rsp_state_ff.seconds;
   assign rsp_ch.beep          = rsp_flags_ff.beep;
   assign rsp_ch.alert         = rsp_flags_ff.alert;

   // Checks
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.seconds <= SecondsTop && state_ff.minutes <= MinutesLimit)
      else $error("timer state out of range");

   a_running_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PHASE_RUNNING |-> (state_ff.minutes != '0 || state_ff.seconds != '0))
      else $error("running with no time left");

   a_alert_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flags_ff.alert |-> rsp_state_ff.phase == PHASE_DONE
                                            && !rsp_flags_ff.beep)
      else $error("alert without entering done");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result lost after advance");

endmodule
